>>> design/bacp_pkg.sv
// Shared types and constants of the bit aligned copy engine.
package bacp_pkg;

  localparam int unsigned MEM_WORDS  = 256;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned WORD_AW    = $clog2(MEM_WORDS);
  localparam int unsigned OFF_W      = $clog2(WORD_BITS);
  localparam int unsigned BIT_AW     = WORD_AW + OFF_W;
  localparam int unsigned TOTAL_BITS = MEM_WORDS * WORD_BITS;
  localparam int unsigned SHAMT_W    = OFF_W + 1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_COPY  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [7:0]  word_addr;
    logic [31:0] word_data;
    logic [12:0] dst_bit_addr;
    logic [12:0] src_bit_addr;
    logic [13:0] bit_count;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        status;
  } out_t;

endpackage

>>> design/bacp_shift.sv
// Shared funnel shifter: right shift of a two word pair, low word kept.
module bacp_shift (
  input  logic [bacp_pkg::WORD_BITS-1:0] hi_i,
  input  logic [bacp_pkg::WORD_BITS-1:0] lo_i,
  input  logic [bacp_pkg::SHAMT_W-1:0]   amt_i,
  output logic [bacp_pkg::WORD_BITS-1:0] out_o
);

  logic [2*bacp_pkg::WORD_BITS-1:0] pair;

  assign pair  = {hi_i, lo_i} >> amt_i;
  assign out_o = pair[bacp_pkg::WORD_BITS-1:0];

endmodule

>>> design/bit_aligned_copy_engine.sv
// Top level of the bit aligned copy engine: sequencer, word memory and merge logic.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i/in_stall_o    | in_item_i  (bacp_pkg::in_t)
//  out     | output    | out_valid_o/out_stall_i  | out_item_o (bacp_pkg::out_t)
//
// One item at a time; in_stall_o is high from acceptance until its result is taken.
// Word write and read pass S_WORD (a read also S_RWAIT) and wait in S_DONE while out stalls.
// Copy works in 32-bit chunks (source lo/hi read, gather, destination
// read-modify-write of one or two words) over the one read and one write memory port.
// Clear zeroes each chunk by destination read-modify-write only. A rejected run skips to S_DONE with status set.
// Reset clears the sequencer and output valid; memory contents are undefined until written.
module bit_aligned_copy_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bacp_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bacp_pkg::out_t out_item_o
);

  localparam int unsigned WB = bacp_pkg::WORD_BITS;
  localparam int unsigned OW = bacp_pkg::OFF_W;
  localparam int unsigned AW = bacp_pkg::WORD_AW;
  localparam int unsigned BW = bacp_pkg::BIT_AW;
  localparam int unsigned SW = bacp_pkg::SHAMT_W;
  localparam int unsigned CW = $bits(in_item_i.bit_count);
  localparam int unsigned XW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WORD,
    S_RWAIT,
    S_CHECK,
    S_CHUNK,
    S_SRC_LO,
    S_SRC_HI,
    S_GATHER,
    S_DST_LO,
    S_DST_HI,
    S_DONE
  } state_e;

  state_e         state_q;
  bacp_pkg::in_t  req_q;
  bacp_pkg::out_t out_q;
  logic           out_valid_q;
  logic [8:0]     chunk_index_q;
  logic [WB-1:0]  src_lo_q;
  logic [WB-1:0]  src_hi_q;
  logic [WB-1:0]  val_q;

  logic [WB-1:0] mem_q [bacp_pkg::MEM_WORDS];
  logic [WB-1:0] mem_rdata_q;
  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic [WB-1:0] mem_wdata;

  logic          is_copy;
  logic          word_ok;
  logic          run_bad;
  logic [CW-1:0] pos;
  logic [CW-1:0] rem;
  logic          run_done;
  logic [SW-1:0] len;
  logic [BW-1:0] dst_cur;
  logic [BW-1:0] src_cur;
  logic [AW-1:0] dst_w;
  logic [AW-1:0] src_w;
  logic [OW-1:0] dst_off;
  logic [OW-1:0] src_off;
  logic [SW:0]   dst_end;
  logic [SW:0]   src_end;
  logic          dst_spill;
  logic          src_need_hi;
  logic [SW-1:0] first;
  logic [SW-1:0] rest;
  logic [WB-1:0] len_mask;
  logic [WB-1:0] lo_mask;
  logic [WB-1:0] hi_mask;

  logic [WB-1:0] sh_hi;
  logic [WB-1:0] sh_lo;
  logic [SW-1:0] sh_amt;
  logic [WB-1:0] sh_out;

  assign is_copy = (req_q.opcode == bacp_pkg::OP_COPY);
  assign word_ok = ({1'b0, AW'(req_q.word_addr)} < (AW + 1)'(bacp_pkg::MEM_WORDS));
  assign run_bad = ((XW'(req_q.dst_bit_addr) + XW'(req_q.bit_count)) >
                    XW'(bacp_pkg::TOTAL_BITS)) ||
                   (is_copy && ((XW'(req_q.src_bit_addr) + XW'(req_q.bit_count)) >
                    XW'(bacp_pkg::TOTAL_BITS)));

  assign pos      = {chunk_index_q, OW'(0)};
  assign run_done = (pos >= req_q.bit_count);
  assign rem      = req_q.bit_count - pos;
  assign len      = (rem > CW'(WB)) ? SW'(WB) : rem[SW-1:0];

  assign dst_cur  = BW'(req_q.dst_bit_addr) + pos[BW-1:0];
  assign src_cur  = BW'(req_q.src_bit_addr) + pos[BW-1:0];
  assign dst_w    = dst_cur[BW-1:OW];
  assign src_w    = src_cur[BW-1:OW];
  assign dst_off  = dst_cur[OW-1:0];
  assign src_off  = src_cur[OW-1:0];
  assign dst_end  = {2'b00, dst_off} + {1'b0, len};
  assign src_end  = {2'b00, src_off} + {1'b0, len};
  assign dst_spill   = (dst_end > (SW + 1)'(WB));
  assign src_need_hi = (src_off != '0) && (src_end > (SW + 1)'(WB));
  assign first    = dst_spill ? (SW'(WB) - {1'b0, dst_off}) : len;
  assign rest     = len - first;

  always_comb begin
    for (int i = 0; i < WB; i++) begin
      len_mask[i] = ((SW + 1)'(i) < {1'b0, len});
      lo_mask[i]  = ((SW + 1)'(i) >= {2'b00, dst_off}) &&
                    ((SW + 1)'(i) < ({2'b00, dst_off} + {1'b0, first}));
      hi_mask[i]  = ((SW + 1)'(i) < {1'b0, rest});
    end
  end

  always_comb begin
    sh_hi  = src_hi_q;
    sh_lo  = src_lo_q;
    sh_amt = {1'b0, src_off};
    case (state_q)
      S_DST_LO: begin
        sh_hi  = val_q;
        sh_lo  = '0;
        sh_amt = SW'(WB) - {1'b0, dst_off};
      end
      S_DST_HI: begin
        sh_hi  = '0;
        sh_lo  = val_q;
        sh_amt = first;
      end
      default: begin
        sh_hi  = src_hi_q;
        sh_lo  = src_lo_q;
        sh_amt = {1'b0, src_off};
      end
    endcase
  end

  bacp_shift u_shift (
    .hi_i  (sh_hi),
    .lo_i  (sh_lo),
    .amt_i (sh_amt),
    .out_o (sh_out)
  );

  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = src_w;
    mem_waddr = dst_w;
    mem_wdata = (mem_rdata_q & ~lo_mask) | (sh_out & lo_mask);
    case (state_q)
      S_WORD: begin
        mem_raddr = AW'(req_q.word_addr);
        mem_waddr = AW'(req_q.word_addr);
        mem_wdata = req_q.word_data;
        mem_re    = word_ok && (req_q.opcode == bacp_pkg::OP_READ);
        mem_we    = word_ok && (req_q.opcode == bacp_pkg::OP_WRITE);
      end
      S_CHUNK: begin
        mem_raddr = is_copy ? src_w : dst_w;
        mem_re    = !run_done;
      end
      S_SRC_LO: begin
        mem_raddr = src_w + AW'(1);
        mem_re    = src_need_hi;
      end
      S_GATHER: begin
        mem_raddr = dst_w;
        mem_re    = 1'b1;
      end
      S_DST_LO: begin
        mem_raddr = dst_w + AW'(1);
        mem_re    = dst_spill;
        mem_we    = 1'b1;
      end
      S_DST_HI: begin
        mem_waddr = dst_w + AW'(1);
        mem_wdata = (mem_rdata_q & ~hi_mask) | (sh_out & hi_mask);
        mem_we    = 1'b1;
      end
      default: begin
        mem_re = 1'b0;
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      req_q         <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
      chunk_index_q <= '0;
      src_lo_q      <= '0;
      src_hi_q      <= '0;
      val_q         <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_item_i;
            out_q <= '0;
            if ((in_item_i.opcode == bacp_pkg::OP_WRITE) ||
                (in_item_i.opcode == bacp_pkg::OP_READ)) begin
              state_q <= S_WORD;
            end else begin
              state_q <= S_CHECK;
            end
          end
        end
        S_WORD: begin
          out_q.status <= !word_ok;
          if (word_ok && (req_q.opcode == bacp_pkg::OP_READ)) begin
            state_q <= S_RWAIT;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= S_DONE;
          end
        end
        S_RWAIT: begin
          out_q.read_data <= mem_rdata_q;
          out_valid_q     <= 1'b1;
          state_q         <= S_DONE;
        end
        S_CHECK: begin
          if (run_bad) begin
            out_q.status <= 1'b1;
            out_valid_q  <= 1'b1;
            state_q      <= S_DONE;
          end else begin
            chunk_index_q <= '0;
            state_q       <= S_CHUNK;
          end
        end
        S_CHUNK: begin
          if (run_done) begin
            out_valid_q <= 1'b1;
            state_q     <= S_DONE;
          end else if (is_copy) begin
            state_q <= S_SRC_LO;
          end else begin
            val_q   <= '0;
            state_q <= S_DST_LO;
          end
        end
        S_SRC_LO: begin
          src_lo_q <= mem_rdata_q;
          src_hi_q <= '0;
          state_q  <= src_need_hi ? S_SRC_HI : S_GATHER;
        end
        S_SRC_HI: begin
          src_hi_q <= mem_rdata_q;
          state_q  <= S_GATHER;
        end
        S_GATHER: begin
          val_q   <= sh_out & len_mask;
          state_q <= S_DST_LO;
        end
        S_DST_LO: begin
          if (dst_spill) begin
            state_q <= S_DST_HI;
          end else begin
            chunk_index_q <= chunk_index_q + 9'd1;
            state_q       <= S_CHUNK;
          end
        end
        S_DST_HI: begin
          chunk_index_q <= chunk_index_q + 9'd1;
          state_q       <= S_CHUNK;
        end
        S_DONE: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
